// ===== hw/rtl/osr_pkg.sv =====
// Shared types and constants for the owner slot table.
// Used by the interfaces, the slot cell and the top level.
`default_nettype none
package osr_pkg;

    localparam int ID_W     = 23;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int STAMP_W  = 64;
    // The table holds at most 256 slots, so a slot number fits in eight bits.
    localparam int SLOT_IDX_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_OWNER = 2'd3
    } t_status;

    // Search result that travels down the row of slot cells.
    typedef struct packed {
        logic                  match_hit;
        logic [SLOT_IDX_W-1:0] match_idx;
        logic                  never_hit;
        logic [SLOT_IDX_W-1:0] never_idx;
        logic                  old_hit;
        logic [SLOT_IDX_W-1:0] old_idx;
        logic [STAMP_W-1:0]    old_stamp;
    } t_scan;

    // Write command broadcast from the controller to every cell.
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  set_owner;
        logic [ID_W-1:0]       owner;
        logic                  set_stamp;
        logic [STAMP_W-1:0]    stamp;
    } t_cell_wr;

endpackage
`default_nettype wire

// ===== hw/rtl/osr_req_if.sv =====
// Request channel of the owner slot table: valid, ready and the request fields.
// Depends on osr_pkg for field widths.
`default_nettype none
interface osr_req_if;
    import osr_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     owner_id;
    logic [ID_W-1:0]     caller_id;

    modport source (output valid, output mode, output owner_id, output caller_id,
                    input ready);
    modport sink   (input valid, input mode, input owner_id, input caller_id,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/osr_rsp_if.sv =====
// Response channel of the owner slot table: valid, ready and the result fields.
// Depends on osr_pkg for field widths.
`default_nettype none
interface osr_rsp_if;
    import osr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/owner_slot_table_with_oldest_reuse_core.sv =====
// Owner slot table with oldest-free reuse: a row of SLOT_COUNT cells and a controller.
// Acquire and release wait for the search to pass the row one cell per cycle, and clear-all
// sweeps the row freeing one slot per cycle; the unused mode skips both and goes straight to
// the result. One request is in work at a time: a new request is taken only after the result
// of the previous one has been registered. Synchronous active-low reset
// frees all slots, zeroes all stamps and sets the tick to one. Needs osr_pkg, the ifs, osr_cell.
`default_nettype none
module owner_slot_table_with_oldest_reuse_core #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    osr_req_if.sink    i_req,
    osr_rsp_if.source  o_rsp
);
    import osr_pkg::*;

    localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DONE  = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_mode              r_mode;
    logic [ID_W-1:0]    r_owner_id;
    logic [ID_W-1:0]    r_caller_id;
    logic [ID_W-1:0]    r_id;
    logic [IdxW-1:0]    r_cnt, n_cnt;
    logic [STAMP_W-1:0] r_tick, n_tick;
    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_slot, n_slot;

    t_scan              w_head;
    t_scan              w_carry [SLOT_COUNT+1];
    t_scan              w_end;
    t_cell_wr           w_wr;
    logic               w_accept;
    logic               w_out_free;
    t_status            w_res_status;
    logic [SLOT_IDX_W-1:0] w_res_idx;
    logic               w_res_write;
    t_cell_wr           w_res_wr;

    // Head of the search chain: nothing found yet, oldest stamp starts at all ones.
    always_comb begin
        w_head           = '0;
        w_head.old_stamp = '1;
    end

    assign w_carry[0] = w_head;

    // Row of slot cells.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        osr_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_id    (r_id),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .i_wr    (w_wr)
        );
    end

    assign w_end      = w_carry[SLOT_COUNT];
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.slot_index = r_slot;

    // Request registers, captured on the accepted beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode      <= t_mode'(i_req.mode);
            r_owner_id  <= i_req.owner_id;
            r_caller_id <= i_req.caller_id;
            r_id        <= (i_req.owner_id != '0) ? i_req.owner_id : i_req.caller_id;
        end
    end

    // Resolve the finished search into a result and an optional slot write.
    always_comb begin
        w_res_status = ST_OK;
        w_res_idx    = '0;
        w_res_write  = 1'b0;
        w_res_wr     = '0;
        unique case (r_mode)
            MODE_ACQUIRE: begin
                if (w_end.match_hit) begin
                    w_res_idx = w_end.match_idx;
                end else if (r_owner_id != '0) begin
                    w_res_status = ST_NOT_FOUND;
                end else if (w_end.never_hit || w_end.old_hit) begin
                    w_res_idx          = w_end.never_hit ? w_end.never_idx : w_end.old_idx;
                    w_res_write        = 1'b1;
                    w_res_wr.set_owner = 1'b1;
                    w_res_wr.owner     = r_caller_id;
                end else begin
                    w_res_status = ST_FULL;
                end
            end
            MODE_RELEASE: begin
                if (!w_end.match_hit) begin
                    w_res_status = ST_NOT_FOUND;
                end else if (r_id != r_caller_id) begin
                    w_res_status = ST_NOT_OWNER;
                end else begin
                    w_res_idx          = w_end.match_idx;
                    w_res_write        = 1'b1;
                    w_res_wr.set_owner = 1'b1;
                    w_res_wr.owner     = '0;
                    w_res_wr.set_stamp = 1'b1;
                    w_res_wr.stamp     = r_tick;
                end
            end
            MODE_CLEAR, MODE_NOP: begin
                w_res_status = ST_OK;
            end
            default: begin
                w_res_status = ST_OK;
            end
        endcase
        w_res_wr.en  = w_res_write;
        w_res_wr.idx = w_res_idx;
    end

    // Controller: scan wait, result hand-off and the clear sweep.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_slot      = r_slot;
        w_wr        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    if (t_mode'(i_req.mode) == MODE_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (t_mode'(i_req.mode) == MODE_NOP) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LastIdx) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                w_wr.en        = 1'b1;
                w_wr.idx       = SLOT_IDX_W'(r_cnt);
                w_wr.set_owner = 1'b1;
                w_wr.owner     = '0;
                w_wr.set_stamp = 1'b1;
                w_wr.stamp     = r_tick;
                n_tick         = r_tick + 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LastIdx) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_wr        = w_res_wr;
                    n_out_valid = 1'b1;
                    n_status    = w_res_status;
                    n_slot      = (w_res_status == ST_OK) ? SLOT_W'(w_res_idx) : '0;
                    if (w_res_wr.set_stamp) begin
                        n_tick = r_tick + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_tick      <= STAMP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/osr_cell.sv =====
// One slot of the table: owner and release stamp, plus one stage of the search chain.
// Depends on osr_pkg for the scan and write structs.
`default_nettype none
module osr_cell #(
    parameter int INDEX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [osr_pkg::ID_W-1:0] i_id,
    input  wire osr_pkg::t_scan     i_carry,
    output osr_pkg::t_scan          o_carry,
    input  wire osr_pkg::t_cell_wr  i_wr
);
    import osr_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] MyIdx = SLOT_IDX_W'(INDEX);

    logic [ID_W-1:0]    r_owner;
    logic [STAMP_W-1:0] r_stamp;
    t_scan              r_carry;
    t_scan              n_carry;
    logic               w_free;

    assign w_free = (r_owner == '0);

    // Merge this slot into the search result handed on from the previous cell.
    always_comb begin
        n_carry = i_carry;
        if (!i_carry.match_hit && r_owner == i_id) begin
            n_carry.match_hit = 1'b1;
            n_carry.match_idx = MyIdx;
        end
        if (w_free && r_stamp == '0) begin
            if (!i_carry.never_hit) begin
                n_carry.never_hit = 1'b1;
                n_carry.never_idx = MyIdx;
            end
        end else if (w_free && r_stamp < i_carry.old_stamp) begin
            // Strict compare keeps the lowest index on ties and never picks all ones.
            n_carry.old_hit   = 1'b1;
            n_carry.old_idx   = MyIdx;
            n_carry.old_stamp = r_stamp;
        end
    end

    // Search stage register toward the next cell.
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

    // Slot contents, written when the broadcast command names this slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_stamp <= '0;
        end else if (i_wr.en && i_wr.idx == MyIdx) begin
            if (i_wr.set_owner) begin
                r_owner <= i_wr.owner;
            end
            if (i_wr.set_stamp) begin
                r_stamp <= i_wr.stamp;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/osr_checker.sv =====
// Port-level checks for the owner slot table, bound to the top level.
// Depends on osr_pkg for the status codes.
`default_nettype none
module osr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [osr_pkg::STATUS_W-1:0] i_status,
    input wire logic [osr_pkg::SLOT_W-1:0]   i_slot_index
);
    import osr_pkg::*;

    // A result beat waiting on the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result keeps its fields.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_status) && $stable(i_slot_index))
        else $error("result fields changed while stalled");

    // Any status other than ok reports slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_slot_index == '0)
        else $error("slot index nonzero on a failed request");

    // One request at a time: the block is busy in the cycle after a request beat.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one still in work");
endmodule

bind owner_slot_table_with_oldest_reuse_core osr_checker u_osr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot_index (o_rsp.slot_index)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the owner slot table with oldest-free reuse.
// Drives osr_req_if beats, predicts each result, and checks osr_rsp_if beats.
// Depends on osr_pkg, osr_req_if, osr_rsp_if and the owner_slot_table_with_oldest_reuse_core RTL.
module tb_top;
    import osr_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RANDOM_REQS = 1000;
    localparam int ID_POOL     = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_START  = 3000;
    localparam int HOLD_LEN    = 400;
    localparam int TAIL_CYCLES = SLOTS + 8;

    // One request beat plus a flag that makes the sender wait for an empty pipeline.
    typedef struct packed {
        t_mode           mode;
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] caller;
        logic            drain;
    } t_slot_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_slot_rsp;

    logic i_clk;
    logic i_rst_n;

    osr_req_if req_ch();
    osr_rsp_if rsp_ch();

    owner_slot_table_with_oldest_reuse_core #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the table used to predict results.
    logic [ID_W-1:0]    shadow_owner [SLOTS];
    logic [STAMP_W-1:0] shadow_stamp [SLOTS];
    logic [STAMP_W-1:0] shadow_tick;

    t_slot_req queued_requests[$];
    t_slot_rsp awaited_results[$];
    logic [ID_W-1:0] id_pool [ID_POOL];

    int  errors;
    int  idle_cycles;
    bit  req_fire_seen;
    int  burst_left;
    int  gap_left;
    int  rx_cycle;
    int  rx_style;
    int  n_acquire, n_release, n_clear, n_other;
    int  n_ok, n_not_found, n_full, n_not_owner;

    // Clock: period of 10.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Lowest slot whose owner equals id, or -1.
    function automatic int first_owned(logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_owner[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void free_entry(int i);
        shadow_owner[i] = '0;
        shadow_stamp[i] = shadow_tick;
        shadow_tick     = shadow_tick + 1'b1;
    endfunction

    // Apply one request to the shadow table and return the result it should give.
    function automatic t_slot_rsp apply_request(t_slot_req r);
        t_slot_rsp          res;
        int                 idx;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] best_stamp;
        res.status = ST_OK;
        res.slot   = '0;
        case (r.mode)
            MODE_ACQUIRE: begin
                if (r.owner != '0) begin
                    idx = first_owned(r.owner);
                    if (idx < 0) res.status = ST_NOT_FOUND;
                    else res.slot = idx[SLOT_W-1:0];
                end else begin
                    idx = first_owned(r.caller);
                    if (idx < 0) begin
                        // A never-released free slot wins; otherwise the oldest stamp.
                        // A stamp of all ones can never be chosen.
                        best_stamp = '1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (shadow_owner[i] == '0) begin
                                if (shadow_stamp[i] == '0) begin
                                    idx = i;
                                    break;
                                end
                                if (shadow_stamp[i] < best_stamp) begin
                                    best_stamp = shadow_stamp[i];
                                    idx        = i;
                                end
                            end
                        end
                        if (idx < 0) begin
                            res.status = ST_FULL;
                        end else begin
                            shadow_owner[idx] = r.caller;
                            res.slot          = idx[SLOT_W-1:0];
                        end
                    end else begin
                        res.slot = idx[SLOT_W-1:0];
                    end
                end
            end
            MODE_RELEASE: begin
                id  = (r.owner != '0) ? r.owner : r.caller;
                idx = first_owned(id);
                if (idx < 0) begin
                    res.status = ST_NOT_FOUND;
                end else if (shadow_owner[idx] != r.caller) begin
                    res.status = ST_NOT_OWNER;
                end else begin
                    free_entry(idx);
                    res.slot = idx[SLOT_W-1:0];
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) free_entry(i);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic add_req(t_mode m, logic [ID_W-1:0] owner, logic [ID_W-1:0] caller,
                           bit drain = 1'b0);
        t_slot_req r;
        r.mode   = m;
        r.owner  = owner;
        r.caller = caller;
        r.drain  = drain;
        queued_requests.push_back(r);
    endtask

    // Request driver: bursts of beats separated by random gaps, changes on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && !req_fire_seen) begin
                // Beat offered but not yet taken: hold it.
                req_ch.valid <= 1'b1;
            end else begin
                if (req_fire_seen) begin
                    void'(queued_requests.pop_front());
                    req_fire_seen = 1'b0;
                end
                if (queued_requests.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (queued_requests[0].drain && awaited_results.size() != 0) begin
                    req_ch.valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else begin
                    req_ch.valid     <= 1'b1;
                    req_ch.mode      <= queued_requests[0].mode;
                    req_ch.owner_id  <= queued_requests[0].owner;
                    req_ch.caller_id <= queued_requests[0].caller;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Result receiver: its own stall pattern, plus one long hold-off.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            rx_cycle++;
            if (rx_cycle % 200 == 0) rx_style = $urandom_range(0, 3);
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                case (rx_style)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 99) < 85);
                    default: rsp_ch.ready <= ((rx_cycle % 8) >= 3);
                endcase
            end
        end
    end

    // Monitor: predict on each request beat, check each result beat, watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (req_ch.valid && req_ch.ready) begin
                t_slot_req r;
                r.mode   = t_mode'(req_ch.mode);
                r.owner  = req_ch.owner_id;
                r.caller = req_ch.caller_id;
                r.drain  = 1'b0;
                req_fire_seen = 1'b1;
                idle_cycles   = 0;
                case (r.mode)
                    MODE_ACQUIRE: n_acquire++;
                    MODE_RELEASE: n_release++;
                    MODE_CLEAR:   n_clear++;
                    default:      n_other++;
                endcase
                awaited_results.push_back(apply_request(r));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                idle_cycles = 0;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with none expected, status %0d slot %0d",
                             $time, rsp_ch.status, rsp_ch.slot_index);
                    errors++;
                end else begin
                    t_slot_rsp want;
                    want = awaited_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.slot_index !== want.slot) begin
                        $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                                 $time, want.slot, rsp_ch.slot_index);
                        errors++;
                    end
                    case (want.status)
                        ST_OK:        n_ok++;
                        ST_NOT_FOUND: n_not_found++;
                        ST_FULL:      n_full++;
                        default:      n_not_owner++;
                    endcase
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, awaited_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int pick;
        logic [ID_W-1:0] a_id;
        logic [ID_W-1:0] b_id;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_NOP;
        req_ch.owner_id  = '0;
        req_ch.caller_id = '0;
        rsp_ch.ready     = 1'b0;
        errors           = 0;
        idle_cycles      = 0;
        req_fire_seen    = 1'b0;
        burst_left       = $urandom_range(1, 30);
        gap_left         = 0;
        rx_cycle         = 0;
        rx_style         = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_owner[i] = '0;
            shadow_stamp[i] = '0;
        end
        shadow_tick = STAMP_W'(1);

        // A small pool of ids so that lookups and releases hit owned slots.
        id_pool[0] = 23'h000001;
        id_pool[1] = 23'h7FFFFF;
        id_pool[2] = 23'h400000;
        for (int i = 3; i < ID_POOL; i++) begin
            id_pool[i] = ID_W'($urandom_range(1, 23'h7FFFFF));
        end

        // Directed part: id extremes, each status, caller zero, unused mode, full table.
        add_req(MODE_ACQUIRE, 23'h7FFFFF, 23'h400000);
        add_req(MODE_ACQUIRE, 23'h000000, 23'h000001);
        add_req(MODE_ACQUIRE, 23'h000000, 23'h7FFFFF);
        add_req(MODE_ACQUIRE, 23'h7FFFFF, 23'h000001);
        add_req(MODE_RELEASE, 23'h000001, 23'h7FFFFF);
        add_req(MODE_RELEASE, 23'h000000, 23'h2AAAAA);
        add_req(MODE_RELEASE, 23'h000000, 23'h000001);
        add_req(MODE_ACQUIRE, 23'h000000, 23'h000000);
        add_req(MODE_RELEASE, 23'h000000, 23'h000000);
        add_req(MODE_NOP,     23'h555555, 23'h2AAAAA);
        // Fill the never-released slots, then the released one by oldest stamp.
        for (int k = 0; k < SLOTS - 1; k++) begin
            add_req(MODE_ACQUIRE, 23'h000000, 23'h7FFFFF ^ (23'h1 << k));
        end
        add_req(MODE_ACQUIRE, 23'h000000, 23'h400000);
        add_req(MODE_ACQUIRE, 23'h000000, 23'h000000);
        add_req(MODE_CLEAR,   23'h000000, 23'h000001);

        // Random part: mostly acquire and release traffic from the id pool.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            a_id = id_pool[$urandom_range(0, ID_POOL - 1)];
            b_id = id_pool[$urandom_range(0, ID_POOL - 1)];
            if (n == 0 || n == RANDOM_REQS / 2) begin
                // Sender waits here until the table has answered everything.
                add_req(MODE_ACQUIRE, '0, a_id, 1'b1);
            end else if (pick < 35) begin
                add_req(MODE_ACQUIRE, '0, a_id);
            end else if (pick < 45) begin
                add_req(MODE_ACQUIRE, a_id, b_id);
            end else if (pick < 68) begin
                add_req(MODE_RELEASE, '0, a_id);
            end else if (pick < 78) begin
                add_req(MODE_RELEASE, a_id, ($urandom_range(0, 1) != 0) ? a_id : b_id);
            end else if (pick < 80) begin
                add_req(($urandom_range(0, 1) != 0) ? MODE_RELEASE : MODE_ACQUIRE, '0, '0);
            end else if (pick < 82) begin
                add_req(MODE_CLEAR, ID_W'($urandom_range(0, 23'h7FFFFF)), a_id);
            end else if (pick < 86) begin
                add_req(MODE_NOP, ID_W'($urandom_range(0, 23'h7FFFFF)),
                        ID_W'($urandom_range(0, 23'h7FFFFF)));
            end else begin
                // Noise: ids from the whole field range, mostly unknown to the table.
                add_req(($urandom_range(0, 1) != 0) ? MODE_RELEASE : MODE_ACQUIRE,
                        ($urandom_range(0, 2) == 0) ? '0 : ID_W'($urandom_range(0, 23'h7FFFFF)),
                        ID_W'($urandom_range(0, 23'h7FFFFF)));
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (queued_requests.size() == 0 && awaited_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d acquire, %0d release, %0d clear, %0d unused mode.",
                 n_acquire + n_release + n_clear + n_other, n_acquire, n_release, n_clear,
                 n_other);
        $display("Results seen: %0d ok, %0d not found, %0d full, %0d non-owner release.",
                 n_ok, n_not_found, n_full, n_not_owner);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
